/* hw/rtl/cau_pkg.sv */
// Shared types, constants and helpers for the complex arithmetic unit.
// No dependencies; used by every module under hw/rtl.
package cau_pkg;

  localparam int FracBits  = 16;              // Q format fraction bits
  localparam int DataW     = 32;              // component width
  localparam int ProdW     = 2 * DataW;       // full product width
  localparam int QBits     = DataW + 1;       // quotient bits kept before cap
  localparam int WideW     = ProdW + QBits;   // divider remainder width
  localparam int LastStg   = QBits + 1;       // last divider pipeline index
  localparam int QDepth    = 2;               // front/back queue entries
  localparam int QPtrW     = $clog2(QDepth);

  typedef enum logic [2:0] {
    FuncAdd  = 3'd0,
    FuncSub  = 3'd1,
    FuncMul  = 3'd2,
    FuncDiv  = 3'd3,
    FuncConj = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StDivZero = 2'd1,
    StSat     = 2'd2
  } status_e;

  // Done: result settled in the front; Mul/Div: back end does the work.
  typedef enum logic [1:0] {
    KindDone = 2'd0,
    KindMul  = 2'd1,
    KindDiv  = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic                    sat;
  } satv_t;

  typedef struct packed {
    kind_e                   kind;
    logic signed [DataW-1:0] a_re;
    logic signed [DataW-1:0] a_im;
    logic signed [DataW-1:0] b_re;
    logic signed [DataW-1:0] b_im;
    logic signed [DataW-1:0] r_re;
    logic signed [DataW-1:0] r_im;
    logic                    sat;
  } item_t;

  // Clamp a wide signed value to DataW bits.
  function automatic satv_t sat_s(input logic signed [ProdW:0] v);
    satv_t r;
    r.sat = !((&v[ProdW:DataW-1]) || ~(|v[ProdW:DataW-1]));
    if (r.sat) begin
      r.val = v[ProdW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      r.val = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/cau_front.sv */
// Front end: decodes the operation and settles add, subtract and conjugate.
// Depends on cau_pkg.
module cau_front (
  input  logic [2:0]                       func_i,
  input  logic signed [cau_pkg::DataW-1:0] a_re_i,
  input  logic signed [cau_pkg::DataW-1:0] a_im_i,
  input  logic signed [cau_pkg::DataW-1:0] b_re_i,
  input  logic signed [cau_pkg::DataW-1:0] b_im_i,
  output cau_pkg::item_t                   item_o
);

  logic signed [cau_pkg::DataW:0] sum_re, sum_im;
  cau_pkg::satv_t                 s_re, s_im;

  always_comb begin
    sum_re = '0;
    sum_im = '0;
    unique case (cau_pkg::func_e'(func_i))
      cau_pkg::FuncAdd: begin
        sum_re = {a_re_i[cau_pkg::DataW-1], a_re_i} + {b_re_i[cau_pkg::DataW-1], b_re_i};
        sum_im = {a_im_i[cau_pkg::DataW-1], a_im_i} + {b_im_i[cau_pkg::DataW-1], b_im_i};
      end
      cau_pkg::FuncSub: begin
        sum_re = {a_re_i[cau_pkg::DataW-1], a_re_i} - {b_re_i[cau_pkg::DataW-1], b_re_i};
        sum_im = {a_im_i[cau_pkg::DataW-1], a_im_i} - {b_im_i[cau_pkg::DataW-1], b_im_i};
      end
      cau_pkg::FuncConj: begin
        sum_re = {b_re_i[cau_pkg::DataW-1], b_re_i};
        sum_im = '0 - {b_im_i[cau_pkg::DataW-1], b_im_i};
      end
      default: begin
        sum_re = '0;
        sum_im = '0;
      end
    endcase
  end

  assign s_re = cau_pkg::sat_s({{(cau_pkg::DataW){sum_re[cau_pkg::DataW]}}, sum_re});
  assign s_im = cau_pkg::sat_s({{(cau_pkg::DataW){sum_im[cau_pkg::DataW]}}, sum_im});

  always_comb begin
    item_o.a_re = a_re_i;
    item_o.a_im = a_im_i;
    item_o.b_re = b_re_i;
    item_o.b_im = b_im_i;
    item_o.r_re = s_re.val;
    item_o.r_im = s_im.val;
    item_o.sat  = s_re.sat | s_im.sat;
    unique case (cau_pkg::func_e'(func_i))
      cau_pkg::FuncMul: item_o.kind = cau_pkg::KindMul;
      cau_pkg::FuncDiv: item_o.kind = cau_pkg::KindDiv;
      default:          item_o.kind = cau_pkg::KindDone;
    endcase
  end

endmodule

/* hw/rtl/cau_fifo.sv */
// Short queue between front and back end.
// Depends on cau_pkg.
module cau_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cau_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cau_pkg::item_t item_o
);

  cau_pkg::item_t               mem_q [cau_pkg::QDepth];
  logic [cau_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [cau_pkg::QPtrW:0]      cnt_q, cnt_d;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == (cau_pkg::QPtrW+1)'(cau_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (cau_pkg::QPtrW+1)'(do_push) - (cau_pkg::QPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* hw/rtl/cau_back.sv */
// Back end: product stage, sum stage, pipelined restoring divider, output register.
// Depends on cau_pkg.
module cau_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cau_pkg::item_t item_i,
  input  logic           avail_i,
  output logic           pop_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [63:0]    m_axis_tdata_o,   // res_re [31:0], res_im [63:32]
  output logic [1:0]     m_axis_tuser_o    // status [1:0]
);

  localparam int DW = cau_pkg::DataW;
  localparam int PW = cau_pkg::ProdW;
  localparam int WW = cau_pkg::WideW;
  localparam int QB = cau_pkg::QBits;

  typedef struct packed {
    logic                   vld;
    cau_pkg::kind_e         kind;
    logic signed [DW-1:0]   r_re;
    logic signed [DW-1:0]   r_im;
    logic                   sat;
    logic signed [PW-1:0]   p_rr;
    logic signed [PW-1:0]   p_ii;
    logic signed [PW-1:0]   p_ir;
    logic signed [PW-1:0]   p_ri;
    logic signed [PW-1:0]   p_bb;
    logic signed [PW-1:0]   p_cc;
  } prod_t;

  typedef struct packed {
    logic                   vld;
    cau_pkg::kind_e         kind;
    logic signed [DW-1:0]   r_re;
    logic signed [DW-1:0]   r_im;
    logic                   sat;
    logic                   dz;
    logic                   neg_re;
    logic                   neg_im;
    logic                   ovf_re;
    logic                   ovf_im;
    logic [WW-1:0]          rem_re;
    logic [WW-1:0]          rem_im;
    logic [PW-1:0]          den;
    logic [QB-1:0]          q_re;
    logic [QB-1:0]          q_im;
  } dv_t;

  prod_t m1_q;
  dv_t   dv_q [cau_pkg::LastStg+1];
  logic  en;

  logic            out_vld_q;
  logic [DW-1:0]   out_re_q, out_im_q, out_re_d, out_im_d;
  logic [1:0]      out_st_q, out_st_d;

  // Sums of products; multiply finishes here, divide sets up numerator and |b|^2.
  function automatic dv_t sum_f(input prod_t m);
    dv_t                  y;
    logic signed [PW:0]   v_re, v_im, n_re, n_im;
    logic [PW:0]          a_re, a_im;
    cau_pkg::satv_t       s_re, s_im;
    y      = '0;
    y.vld  = m.vld;
    y.kind = m.kind;
    v_re   = {m.p_rr[PW-1], m.p_rr} - {m.p_ii[PW-1], m.p_ii};
    v_im   = {m.p_ir[PW-1], m.p_ir} + {m.p_ri[PW-1], m.p_ri};
    s_re   = cau_pkg::sat_s(v_re >>> cau_pkg::FracBits);
    s_im   = cau_pkg::sat_s(v_im >>> cau_pkg::FracBits);
    n_re   = {m.p_rr[PW-1], m.p_rr} + {m.p_ii[PW-1], m.p_ii};
    n_im   = {m.p_ir[PW-1], m.p_ir} - {m.p_ri[PW-1], m.p_ri};
    a_re   = n_re[PW] ? (PW+1)'(0) - n_re : n_re;
    a_im   = n_im[PW] ? (PW+1)'(0) - n_im : n_im;
    y.neg_re = n_re[PW];
    y.neg_im = n_im[PW];
    y.rem_re = WW'(a_re[PW-1:0]);
    y.rem_im = WW'(a_im[PW-1:0]);
    y.den    = $unsigned(m.p_bb) + $unsigned(m.p_cc);
    y.dz     = (m.p_bb == '0) && (m.p_cc == '0);
    if (m.kind == cau_pkg::KindMul) begin
      y.r_re = s_re.val;
      y.r_im = s_im.val;
      y.sat  = s_re.sat | s_im.sat;
    end else begin
      y.r_re = m.r_re;
      y.r_im = m.r_im;
      y.sat  = m.sat;
    end
    return y;
  endfunction

  // Stage 1: scale and check quotient overflow; later stages: one quotient bit.
  function automatic dv_t step_f(input dv_t x, input int j);
    dv_t           y;
    logic [WW-1:0] thr;
    y = x;
    if (j == 1) begin
      y.rem_re = x.rem_re << cau_pkg::FracBits;
      y.rem_im = x.rem_im << cau_pkg::FracBits;
      thr      = WW'(x.den) << QB;
      y.ovf_re = (y.rem_re >= thr);
      y.ovf_im = (y.rem_im >= thr);
    end else begin
      thr = WW'(x.den) << (QB + 1 - j);
      if (x.rem_re >= thr) begin
        y.rem_re           = x.rem_re - thr;
        y.q_re[QB + 1 - j] = 1'b1;
      end
      if (x.rem_im >= thr) begin
        y.rem_im           = x.rem_im - thr;
        y.q_im[QB + 1 - j] = 1'b1;
      end
    end
    return y;
  endfunction

  function automatic cau_pkg::satv_t pack_f(input logic neg, input logic ovf,
                                            input logic [QB-1:0] q);
    cau_pkg::satv_t r;
    if (!neg) begin
      r.sat = ovf | q[QB-1] | q[DW-1];
      r.val = r.sat ? {1'b0, {(DW-1){1'b1}}} : q[DW-1:0];
    end else begin
      r.sat = ovf | q[QB-1] | (q[DW-1] & (|q[DW-2:0]));
      r.val = r.sat ? {1'b1, {(DW-1){1'b0}}} : DW'(0) - q[DW-1:0];
    end
    return r;
  endfunction

  // Whole back end advances together when the output register can move.
  assign en    = !out_vld_q || m_axis_tready_i;
  assign pop_o = en && avail_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      for (int j = 0; j <= cau_pkg::LastStg; j++) begin
        dv_q[j] <= '0;
      end
      out_vld_q <= 1'b0;
      out_re_q  <= '0;
      out_im_q  <= '0;
      out_st_q  <= '0;
    end else if (en) begin
      m1_q.vld  <= avail_i;
      m1_q.kind <= item_i.kind;
      m1_q.r_re <= item_i.r_re;
      m1_q.r_im <= item_i.r_im;
      m1_q.sat  <= item_i.sat;
      m1_q.p_rr <= item_i.a_re * item_i.b_re;
      m1_q.p_ii <= item_i.a_im * item_i.b_im;
      m1_q.p_ir <= item_i.a_im * item_i.b_re;
      m1_q.p_ri <= item_i.a_re * item_i.b_im;
      m1_q.p_bb <= item_i.b_re * item_i.b_re;
      m1_q.p_cc <= item_i.b_im * item_i.b_im;
      // Valid bits travel inside the stage structs.
      dv_q[0]   <= sum_f(m1_q);
      for (int j = 1; j <= cau_pkg::LastStg; j++) begin
        dv_q[j] <= step_f(dv_q[j-1], j);
      end
      out_vld_q <= dv_q[cau_pkg::LastStg].vld;
      out_re_q  <= out_re_d;
      out_im_q  <= out_im_d;
      out_st_q  <= out_st_d;
    end
  end

  always_comb begin
    cau_pkg::satv_t pr, pi;
    pr = pack_f(dv_q[cau_pkg::LastStg].neg_re, dv_q[cau_pkg::LastStg].ovf_re,
                dv_q[cau_pkg::LastStg].q_re);
    pi = pack_f(dv_q[cau_pkg::LastStg].neg_im, dv_q[cau_pkg::LastStg].ovf_im,
                dv_q[cau_pkg::LastStg].q_im);
    if (dv_q[cau_pkg::LastStg].kind == cau_pkg::KindDiv) begin
      if (dv_q[cau_pkg::LastStg].dz) begin
        out_re_d = '0;
        out_im_d = '0;
        out_st_d = cau_pkg::StDivZero;
      end else begin
        out_re_d = pr.val;
        out_im_d = pi.val;
        out_st_d = (pr.sat | pi.sat) ? cau_pkg::StSat : cau_pkg::StOk;
      end
    end else begin
      out_re_d = dv_q[cau_pkg::LastStg].r_re;
      out_im_d = dv_q[cau_pkg::LastStg].r_im;
      out_st_d = dv_q[cau_pkg::LastStg].sat ? cau_pkg::StSat : cau_pkg::StOk;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_im_q, out_re_q};
  assign m_axis_tuser_o  = out_st_q;

endmodule

/* hw/rtl/complex_arithmetic_unit.sv */
// Complex arithmetic unit, signed Q16.16: add, subtract, multiply, divide, conjugate.
// Depends on cau_pkg, cau_front, cau_fifo, cau_back.
//
// Usage:
//  - Input stream (s_axis): tdata carries a_re, a_im, b_re, b_im (32 bits each,
//    lowest first); tuser carries the 3-bit operation code.
//  - Output stream (m_axis): tdata carries res_re then res_im; tuser carries
//    status (ok, divide by zero, saturated).
//  - Exactly one result per request, in request order.
//  - Every operation takes the same path from input handshake to output
//    valid: queue read with products, sums, divider scale/overflow,
//    one quotient bit per stage for 33 stages, output register.
//  - Throughput: one request per cycle unless the receiver stalls; the divider is fully pipelined.
//  - The front decodes and finishes add/subtract/conjugate, then writes a
//    2-entry queue; the back pulls from it whenever its pipeline can move.
//  - Receiver stall: the whole back pipeline holds while the output register
//    is full and m_axis_tready_i is low; the queue fills, then s_axis_tready_o
//    drops. No request is lost.
//  - Reset (rst_ni low, async): queue emptied, all pipeline valids cleared.
module complex_arithmetic_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [127:0]  s_axis_tdata_i,  // a_re [31:0], a_im [63:32], b_re [95:64], b_im [127:96]
  input  logic [2:0]    s_axis_tuser_i,  // func [2:0]
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [63:0]   m_axis_tdata_o,  // res_re [31:0], res_im [63:32]
  output logic [1:0]    m_axis_tuser_o   // status [1:0]
);

  cau_pkg::item_t front_item, q_item;
  logic           q_full, q_empty, back_pop;

  // Front: decode and settle the simple operations.
  cau_front u_front (
    .func_i (s_axis_tuser_i),
    .a_re_i (s_axis_tdata_i[31:0]),
    .a_im_i (s_axis_tdata_i[63:32]),
    .b_re_i (s_axis_tdata_i[95:64]),
    .b_im_i (s_axis_tdata_i[127:96]),
    .item_o (front_item)
  );

  // Decouples input acceptance from back-end stalls.
  cau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid_i),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  assign s_axis_tready_o = !q_full;

  // Back: multiply, divide and output register.
  cau_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (q_item),
    .avail_i         (!q_empty),
    .pop_o           (back_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

/* hw/rtl/cau_checker.sv */
// Port-level checks for complex_arithmetic_unit, attached by bind.
// Depends on cau_pkg.
module cau_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [63:0]  m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);

  // Held result stays put while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  // Nothing valid right out of reset.
  a_rst_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid out of reset");

  // Divide by zero always returns zero.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == cau_pkg::StDivZero |-> m_axis_tdata_o == '0)
    else $error("divide by zero with nonzero result");

  // Status code 3 is never produced.
  a_st_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == cau_pkg::StOk ||
                         m_axis_tuser_o == cau_pkg::StDivZero ||
                         m_axis_tuser_o == cau_pkg::StSat))
    else $error("bad status code");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
